// File: src/rgbd_pkg.sv
// ----------------------------------------------------------------------------
// rgbd_pkg: shared definitions for the RGB332 error-diffusion ditherer
// Field widths, register indexes, diffusion weights and lane control type.
// ----------------------------------------------------------------------------
package rgbd_pkg;

   localparam int PIX_W     = 8;
   localparam int WIDTH_W   = 12;
   localparam int OUT_W     = 8;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd320;

   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DITHER_ENABLE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH   = 1'b1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // Floyd-Steinberg weights in sixteenths.
   localparam int W_RIGHT      = 7;
   localparam int W_DOWN_LEFT  = 3;
   localparam int W_DOWN       = 5;
   localparam int W_SHIFT      = 4;

   // Bits kept per channel and widths of the down sums in the line store.
   localparam int RED_KEEP_W   = 3;
   localparam int GREEN_KEEP_W = 3;
   localparam int BLUE_KEEP_W  = 2;
   localparam int RED_DOWN_W   = 4;
   localparam int GREEN_DOWN_W = 4;
   localparam int BLUE_DOWN_W  = 6;
   localparam int ENTRY_W      = RED_DOWN_W + GREEN_DOWN_W + BLUE_DOWN_W;

   typedef struct packed {
      logic advance;
      logic dither;
      logic first_row;
      logic frame_start;
      logic last;
   } lane_ctrl_type;

endpackage

// File: src/rgbd_lane.sv
// ----------------------------------------------------------------------------
// rgbd_lane: one color channel of the ditherer
// Adds the diffused error and saturates when dithering, truncates and spreads the new error.
// ----------------------------------------------------------------------------
module rgbd_lane #(
   parameter int KEEP_W = 3,
   parameter int DOWN_W = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rgbd_pkg::lane_ctrl_type    ctrl,
   input  logic [rgbd_pkg::PIX_W-1:0] pix,
   input  logic [DOWN_W-1:0]          above,
   output logic [KEEP_W-1:0]          quant,
   output logic [DOWN_W-1:0]          down_left,
   output logic [DOWN_W-1:0]          down_here
);
   import rgbd_pkg::*;

   localparam int ERR_W = PIX_W - KEEP_W;
   localparam int RC_W  = ERR_W - 1;
   localparam int MUL_W = ERR_W + 3;
   localparam int SUM_W = PIX_W + 2;

   logic [RC_W-1:0]   carry_ff, carry_in, carry_use;
   logic [DOWN_W-1:0] pend0_ff, pend0_in, pend0_use;
   logic [DOWN_W-1:0] pend1_ff, pend1_in, pend1_use;
   logic [DOWN_W-1:0] above_use;
   logic [SUM_W-1:0]  sum;
   logic [PIX_W-1:0]  value;
   logic [ERR_W-1:0]  err;
   logic [MUL_W-1:0]  e3, e5, e7;

   always_comb begin
      carry_use = ctrl.frame_start ? '0 : carry_ff;
      pend0_use = ctrl.frame_start ? '0 : pend0_ff;
      pend1_use = ctrl.frame_start ? '0 : pend1_ff;
      above_use = ctrl.first_row ? '0 : above;
      sum = SUM_W'(pix) + SUM_W'(carry_use) + SUM_W'(above_use);
      if (!ctrl.dither) begin
         value = pix;
      end else if (sum > SUM_W'(PIX_MAX)) begin
         value = PIX_MAX;
      end else begin
         value = sum[PIX_W-1:0];
      end
      quant = value[PIX_W-1:ERR_W];
      err   = ctrl.dither ? value[ERR_W-1:0] : '0;
      e3 = MUL_W'(err) * MUL_W'(W_DOWN_LEFT);
      e5 = MUL_W'(err) * MUL_W'(W_DOWN);
      e7 = MUL_W'(err) * MUL_W'(W_RIGHT);
      down_left = pend0_use + DOWN_W'(e3[MUL_W-1:W_SHIFT]);
      down_here = pend1_use + DOWN_W'(e5[MUL_W-1:W_SHIFT]);
      if (ctrl.last) begin
         pend0_in = '0;
         pend1_in = '0;
         carry_in = '0;
      end else begin
         pend0_in = down_here;
         pend1_in = DOWN_W'(err[ERR_W-1:W_SHIFT]);
         carry_in = e7[MUL_W-1:W_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
         pend0_ff <= '0;
         pend1_ff <= '0;
      end else if (ctrl.advance) begin
         carry_ff <= carry_in;
         pend0_ff <= pend0_in;
         pend1_ff <= pend1_in;
      end
   end

endmodule

// File: src/rgbd_line_store.sv
// ----------------------------------------------------------------------------
// rgbd_line_store: line memory for the down error sums
// One write port, registered read with forwarding, and a held row-end entry.
// ----------------------------------------------------------------------------
module rgbd_line_store #(
   parameter int DEPTH = rgbd_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [rgbd_pkg::ENTRY_W-1:0] wr_data,
   input  logic                         tail_load,
   input  logic [$clog2(DEPTH)-1:0]     tail_addr,
   input  logic [rgbd_pkg::ENTRY_W-1:0] tail_data,
   output logic [rgbd_pkg::ENTRY_W-1:0] rd_data
);
   import rgbd_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [ENTRY_W-1:0] fwd_data_ff, fwd_data_in;
   logic               tail_valid_ff, tail_valid_in;
   logic [ADDR_W-1:0]  tail_addr_ff;
   logic [ENTRY_W-1:0] tail_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // The held row-end entry is written in the first cycle the port is free.
   always_comb begin
      mem_we    = wr_en || tail_valid_ff;
      mem_waddr = wr_en ? wr_addr : tail_addr_ff;
      mem_wdata = wr_en ? wr_data : tail_data_ff;
      if (tail_load) begin
         tail_valid_in = 1'b1;
      end else if (!wr_en) begin
         tail_valid_in = 1'b0;
      end else begin
         tail_valid_in = tail_valid_ff;
      end
      if (wr_en && wr_addr == rd_addr) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = wr_data;
      end else if (tail_load && tail_addr == rd_addr) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = tail_data;
      end else if (tail_valid_ff && tail_addr_ff == rd_addr) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = tail_data_ff;
      end else begin
         fwd_hit_in  = 1'b0;
         fwd_data_in = wr_data;
      end
      rd_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= fwd_data_in;
      end
      if (tail_load) begin
         tail_addr_ff <= tail_addr;
         tail_data_ff <= tail_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff    <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         tail_valid_ff <= tail_valid_in;
      end
   end

endmodule

// File: src/rgb332_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// rgb332_error_diffusion_dither: 24-bit RGB to RGB332 with error diffusion
// Two register stages: the accepted word is held in the input stage, and its
// result word is registered in the output stage when the input stage advances.
// Throughput: one word per cycle unless the sink stalls, set by the right-carry
// loop in each channel lane and one line store read and write per pixel.
// Reset clears the handshake, carries, column and dither bit; width becomes 320.
// The line store is not cleared; the first row of each frame ignores it.
// ----------------------------------------------------------------------------
module rgb332_error_diffusion_dither #(
   parameter int MAX_WIDTH = rgbd_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [3*rgbd_pkg::PIX_W-1:0]    req_tdata,  // red, green, blue
   input  logic                            req_tuser,  // frame_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rgbd_pkg::OUT_W-1:0]      rsp_tdata,  // packed_pixel
   input  logic                            csr_wen,
   input  logic [rgbd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rgbd_pkg::WIDTH_W-1:0]    csr_wdata
);
   import rgbd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (COL_W >= WIDTH_W) ? COL_W + 1 : WIDTH_W + 1;

   logic                dither_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [COL_W-1:0]    col_ff, col_in, col_cur;
   logic                first_ff, first_in, first_cur;
   logic [CMP_W-1:0]    width_eff;
   logic                last_cur;
   logic                accept;

   logic                a_valid_ff;
   logic [3*PIX_W-1:0]  a_pix_ff;
   logic [COL_W-1:0]    a_col_ff;
   logic                a_last_ff, a_first_ff, a_fs_ff;
   logic                advance;
   lane_ctrl_type       ctrl;

   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_data_ff;

   logic [ENTRY_W-1:0]  above;
   logic [ENTRY_W-1:0]  dl_entry, here_entry;
   logic [RED_KEEP_W-1:0]   q_red;
   logic [GREEN_KEEP_W-1:0] q_green;
   logic [BLUE_KEEP_W-1:0]  q_blue;
   logic [RED_DOWN_W-1:0]   dl_red, here_red;
   logic [GREEN_DOWN_W-1:0] dl_green, here_green;
   logic [BLUE_DOWN_W-1:0]  dl_blue, here_blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_ff <= 1'b0;
         width_ff  <= WIDTH_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_DITHER_ENABLE: dither_ff <= csr_wdata[0];
            CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata;
         endcase
      end
   end

   // Column tracking happens at acceptance so the line store read can start.
   always_comb begin
      if (width_ff == '0) begin
         width_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = CMP_W'(width_ff);
      end
      col_cur   = req_tuser ? '0 : col_ff;
      first_cur = req_tuser ? 1'b1 : first_ff;
      last_cur  = (CMP_W'(col_cur) + CMP_W'(1)) >= width_eff;
      col_in    = last_cur ? '0 : col_cur + COL_W'(1);
      first_in  = last_cur ? 1'b0 : first_cur;
   end

   assign advance    = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_ff     <= 1'b1;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff   <= col_in;
            first_ff <= first_in;
         end
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (advance) begin
            a_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff   <= req_tdata;
         a_col_ff   <= col_cur;
         a_last_ff  <= last_cur;
         a_first_ff <= first_cur;
         a_fs_ff    <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= {q_red, q_green, q_blue};
      end
   end

   always_comb begin
      ctrl.advance     = advance;
      ctrl.dither      = dither_ff;
      ctrl.first_row   = a_first_ff;
      ctrl.frame_start = a_fs_ff;
      ctrl.last        = a_last_ff;
   end

   rgbd_lane #(.KEEP_W(RED_KEEP_W), .DOWN_W(RED_DOWN_W)) u_red (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .pix       (a_pix_ff[PIX_W-1:0]),
      .above     (above[RED_DOWN_W-1:0]),
      .quant     (q_red),
      .down_left (dl_red),
      .down_here (here_red)
   );

   rgbd_lane #(.KEEP_W(GREEN_KEEP_W), .DOWN_W(GREEN_DOWN_W)) u_green (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .pix       (a_pix_ff[2*PIX_W-1:PIX_W]),
      .above     (above[RED_DOWN_W+GREEN_DOWN_W-1:RED_DOWN_W]),
      .quant     (q_green),
      .down_left (dl_green),
      .down_here (here_green)
   );

   rgbd_lane #(.KEEP_W(BLUE_KEEP_W), .DOWN_W(BLUE_DOWN_W)) u_blue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .pix       (a_pix_ff[3*PIX_W-1:2*PIX_W]),
      .above     (above[ENTRY_W-1:RED_DOWN_W+GREEN_DOWN_W]),
      .quant     (q_blue),
      .down_left (dl_blue),
      .down_here (here_blue)
   );

   assign dl_entry   = {dl_blue, dl_green, dl_red};
   assign here_entry = {here_blue, here_green, here_red};

   rgbd_line_store #(.DEPTH(MAX_WIDTH)) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (col_cur),
      .wr_en     (advance && a_col_ff != '0),
      .wr_addr   (a_col_ff - COL_W'(1)),
      .wr_data   (dl_entry),
      .tail_load (advance && a_last_ff),
      .tail_addr (a_col_ff),
      .tail_data (here_entry),
      .rd_data   (above)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sim/dither_result_checker.sv
// ----------------------------------------------------------------------------
// dither_result_checker: predicts and checks the RGB332 ditherer's output
// Watches the pixel, result and register channels of the ditherer. Each
// accepted pixel is run through an independent model of the error diffusion
// and the predicted byte is queued. Each accepted result word is compared
// with the oldest queued byte. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module dither_result_checker
   import rgbd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [3*PIX_W-1:0]      req_tdata,
   input  logic                    req_tuser,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [OUT_W-1:0]        rsp_tdata,
   input  logic                    csr_wen,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [WIDTH_W-1:0]      csr_wdata,
   output int                      fail_count,
   output int                      outstanding
);

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   logic                       dither_on;
   logic [WIDTH_W-1:0]         width_reg;
   logic [2:0][BLUE_DOWN_W-1:0] row_err [MAX_WIDTH];
   logic [2:0][BLUE_DOWN_W-2:0] carry;
   logic [2:0][BLUE_DOWN_W-1:0] pend_left;
   logic [2:0][BLUE_DOWN_W-1:0] pend_here;
   int unsigned                col_pos;
   logic                       first_row;

   logic [OUT_W-1:0]           expected_pixels [$];
   logic [OUT_W-1:0]           want;
   int                         mismatches;

   function automatic logic [PIX_W-1:0] keep_mask(input int ch);
      int keep;
      keep = (ch == CH_RED) ? RED_KEEP_W : (ch == CH_GREEN) ? GREEN_KEEP_W : BLUE_KEEP_W;
      return ~(PIX_MAX >> keep);
   endfunction

   function automatic logic [OUT_W-1:0] predict_pixel(input logic [3*PIX_W-1:0] rgb,
                                                      input logic sof);
      int unsigned w, col, v, e, p0;
      logic last_col;
      logic [2:0][PIX_W-1:0] q;
      if (sof) begin
         col_pos   = 0;
         first_row = 1'b1;
         carry     = '0;
         pend_left = '0;
         pend_here = '0;
      end
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      col = col_pos;
      last_col = (col + 1 >= w);
      for (int c = CH_RED; c <= CH_BLUE; c++) begin
         v = rgb[PIX_W*c +: PIX_W];
         e = 0;
         if (dither_on) begin
            v = v + carry[c];
            if (!first_row) v = v + row_err[col][c];
            if (v > PIX_MAX) v = PIX_MAX;
         end
         q[c] = PIX_W'(v) & keep_mask(c);
         if (dither_on) e = v - q[c];
         if (col > 0) row_err[col-1][c] = pend_left[c] + ((e * W_DOWN_LEFT) >> W_SHIFT);
         p0 = pend_here[c] + ((e * W_DOWN) >> W_SHIFT);
         if (last_col) begin
            row_err[col][c] = p0;
            pend_left[c] = '0;
            pend_here[c] = '0;
            carry[c] = '0;
         end else begin
            pend_left[c] = p0;
            pend_here[c] = e >> W_SHIFT;
            carry[c] = (e * W_RIGHT) >> W_SHIFT;
         end
      end
      if (last_col) begin
         col_pos = 0;
         first_row = 1'b0;
      end else begin
         col_pos = col + 1;
      end
      return q[CH_RED] | (q[CH_GREEN] >> RED_KEEP_W)
             | (q[CH_BLUE] >> (RED_KEEP_W + GREEN_KEEP_W));
   endfunction

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         dither_on = 1'b0;
         width_reg = WIDTH_RESET;
         carry     = '0;
         pend_left = '0;
         pend_here = '0;
         col_pos   = 0;
         first_row = 1'b1;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("packed_pixel: no word expected, actual %02h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want) begin
                  $error("packed_pixel: expected %02h, actual %02h", want, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (csr_wen) begin
            case (csr_addr)
               CSR_DITHER_ENABLE: dither_on = csr_wdata[0];
               CSR_IMAGE_WIDTH:   width_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(predict_pixel(req_tdata, req_tuser));
      end
      fail_count  <= mismatches;
      outstanding <= expected_pixels.size();
   end

endmodule

// File: sim/tb_rgb332_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// tb_rgb332_error_diffusion_dither: stimulus and verdict for the ditherer
// Drives directed pixels over the channel extremes, narrow widths, a zero
// width, a width shrunk mid-row and the widest rows, then random frames under
// three patterns of source and sink idling with one long sink stall.
// ----------------------------------------------------------------------------
module tb_rgb332_error_diffusion_dither;
   import rgbd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL  = 300;
   localparam int RANDOM_PER_MODE = 330;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [3*PIX_W-1:0]    req_tdata;   // red, green, blue
   logic                  req_tuser;   // frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_W-1:0]      rsp_tdata;   // packed_pixel
   logic                  csr_wen;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [WIDTH_W-1:0]    csr_wdata;

   int fail_count;
   int outstanding;
   int cycle_count;
   int source_idle_pct;
   int sink_idle_pct;
   logic long_stall_req;
   int pixels_sent;
   int frames_sent;
   int settings_used;

   rgb332_error_diffusion_dither u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   dither_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL rgb332_error_diffusion_dither");
      $finish;
   end

   // Sink side: random backpressure, plus one long stall on request.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            long_stall_req = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   function automatic logic [3*PIX_W-1:0] pack_rgb(input logic [PIX_W-1:0] r,
                                                   input logic [PIX_W-1:0] g,
                                                   input logic [PIX_W-1:0] b);
      return {b, g, r};
   endfunction

   // Values at and around the quantization steps show up often.
   function automatic logic [PIX_W-1:0] random_channel();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return PIX_MAX;
         2: return 8'h1F;
         3: return 8'h3F;
         4: return 8'hE0 | PIX_W'($urandom_range(31));
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixel(input logic [3*PIX_W-1:0] rgb, input logic sof);
      while ($urandom_range(99) < source_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rgb;
      req_tuser  <= sof;
      pixels_sent++;
      if (sof) frames_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [WIDTH_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input logic dither, input logic [WIDTH_W-1:0] width);
      drain();
      write_csr(CSR_DITHER_ENABLE, WIDTH_W'(dither));
      write_csr(CSR_IMAGE_WIDTH, width);
      settings_used++;
   endtask

   // Mostly whole frames of a few rows; the rest have a random length of up to three rows.
   // Without new_frame the first pixels continue the row already in progress.
   task automatic run_phase(input logic dither, input logic [WIDTH_W-1:0] width,
                            input int count, input logic new_frame);
      int sent, frame_len, eff_w, k;
      set_mode(dither, width);
      eff_w = (width == 0) ? 1 : (width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 8) frame_len = eff_w * $urandom_range(1, 4);
         else frame_len = $urandom_range(1, 3 * eff_w);
         for (k = 0; k < frame_len && sent < count; k++) begin
            send_pixel({random_channel(), random_channel(), random_channel()},
                       (k == 0) && (new_frame || sent > 0));
            sent++;
         end
      end
   endtask

   task automatic random_phases(input int total);
      int sent, n;
      logic [WIDTH_W-1:0] width;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(19))
            0: width = WIDTH_W'($urandom_range(65, 300));
            1, 2, 3, 4, 5: width = WIDTH_W'($urandom_range(13, 64));
            default: width = WIDTH_W'($urandom_range(1, 12));
         endcase
         n = $urandom_range(60, 150);
         run_phase($urandom_range(9) < 8, width, n, 1'b1);
         sent += n;
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= 1'b0;
      csr_wen        <= 1'b0;
      csr_addr       <= CSR_DITHER_ENABLE;
      csr_wdata      <= '0;
      long_stall_req = 1'b0;
      pixels_sent    = 0;
      frames_sent    = 0;
      settings_used  = 0;
      source_idle_pct = 34;
      sink_idle_pct   = 85;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: plain truncation of the channel extremes.
      send_pixel(pack_rgb(8'h00, 8'h00, 8'h00), 1'b1);
      send_pixel(pack_rgb(8'hFF, 8'hFF, 8'hFF), 1'b0);
      send_pixel(pack_rgb(8'h1F, 8'h1F, 8'h3F), 1'b0);
      send_pixel(pack_rgb(8'hE0, 8'hE0, 8'hC0), 1'b0);
      send_pixel(pack_rgb(8'hA5, 8'h5A, 8'h96), 1'b0);

      // One-pixel rows: every pixel ends a row and feeds the next one down.
      set_mode(1'b1, 12'd1);
      send_pixel(pack_rgb(8'h1F, 8'h1F, 8'h3F), 1'b1);
      send_pixel(pack_rgb(8'h1F, 8'h1F, 8'h3F), 1'b0);
      send_pixel(pack_rgb(8'hFF, 8'hFF, 8'hFF), 1'b0);
      send_pixel(pack_rgb(8'h10, 8'h90, 8'h21), 1'b0);

      // A zero width behaves as one pixel per row.
      set_mode(1'b1, 12'd0);
      send_pixel(pack_rgb(8'h3F, 8'h3F, 8'h3F), 1'b1);
      send_pixel(pack_rgb(8'hF0, 8'hF0, 8'hF0), 1'b0);
      send_pixel(pack_rgb(8'hFE, 8'hFD, 8'hFF), 1'b0);

      // Large errors pile up and saturate on the second row.
      set_mode(1'b1, 12'd4);
      send_pixel(pack_rgb(8'h1F, 8'h1F, 8'h3F), 1'b1);
      send_pixel(pack_rgb(8'hFF, 8'hFF, 8'hFF), 1'b0);
      send_pixel(pack_rgb(8'h1F, 8'h1F, 8'h3F), 1'b0);
      send_pixel(pack_rgb(8'hF8, 8'hF8, 8'hF8), 1'b0);
      send_pixel(pack_rgb(8'hF0, 8'hF0, 8'hF0), 1'b0);
      send_pixel(pack_rgb(8'h1F, 8'h1F, 8'h3F), 1'b0);

      // Width shrinks while a row is under way: the next pixel ends the row.
      set_mode(1'b1, 12'd2);
      send_pixel(pack_rgb(8'h5F, 8'h7F, 8'h7F), 1'b0);
      send_pixel(pack_rgb(8'h1F, 8'h1F, 8'h3F), 1'b0);
      send_pixel(pack_rgb(8'hFF, 8'h00, 8'hFF), 1'b0);

      // Widest rows, then a width beyond the store that is clamped to it.
      run_phase(1'b1, WIDTH_W'(MAX_WIDTH_DEF), 30, 1'b1);
      run_phase(1'b1, 12'hFFF, 60, 1'b1);

      random_phases(RANDOM_PER_MODE);

      source_idle_pct = 85;
      sink_idle_pct   = 34;
      random_phases(RANDOM_PER_MODE);

      source_idle_pct = 0;
      sink_idle_pct   = 0;
      long_stall_req  = 1'b1;
      random_phases(RANDOM_PER_MODE);

      drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d pixels in %0d frames over %0d register settings,",
               pixels_sent, frames_sent, settings_used);
      $display("with widths from zero to beyond the store and a long sink stall.");
      if (fail_count == 0) begin
         $display("PASS rgb332_error_diffusion_dither");
      end else begin
         $display("FAIL rgb332_error_diffusion_dither");
      end
      $finish;
   end

endmodule
